FILE: sv/owbe_pkg.sv
package owbe_pkg;

    localparam int ROM_BITS = 64;
    localparam int ID_BITS  = 56;
    localparam int ID_BYTES = ID_BITS / 8;
    localparam int TXW      = $clog2(ROM_BITS);
    localparam int US_W     = 12;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Command bytes
    localparam logic [7:0] CMD_SEARCH_ROM = 8'hF0;
    localparam logic [7:0] CMD_READ_ROM   = 8'h33;
    localparam logic [7:0] CMD_ALARM      = 8'hEC;
    localparam logic [7:0] CMD_MATCH_ROM  = 8'h55;
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_RESUME     = 8'hA5;

    // Bus actions
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_RELEASE  = 2'd1;
    localparam logic [1:0] ACT_LOW      = 2'd2;
    localparam logic [1:0] ACT_PRESENCE = 2'd3;

    // Event kinds
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_RESET = 2'd1;
    localparam logic [1:0] EV_BYTE  = 2'd2;

    // Register indexes (byte address 8*i)
    localparam logic [2:0] REG_ROM_ID        = 3'd0;
    localparam logic [2:0] REG_RESET_MIN     = 3'd1;
    localparam logic [2:0] REG_BIT_MAX       = 3'd2;
    localparam logic [2:0] REG_SAMPLE        = 3'd3;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd4;
    localparam logic [2:0] REG_PRESENCE_LEN  = 3'd5;
    localparam logic [2:0] REG_SEND_BIT      = 3'd6;

    typedef struct packed {
        logic [1:0]      bus_action;
        logic [US_W-1:0] start_delay_us;
        logic [US_W-1:0] low_len_us;
        logic [1:0]      event_kind;
        logic [7:0]      event_byte;
    } result_t;

    // Reflected CRC-8 over one data byte, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        logic       mix;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            mix = crc[0] ^ data[i];
            crc = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

FILE: sv/one_wire_slave_bit_engine_unit.sv
// 1-Wire slave bit engine with Read ROM and Search ROM.
// Input channel (in_valid/in_ready, pulse_us): one measured low pulse per item.
// Output channel (out_valid/out_ready): exactly one result item per input item,
// telling the bus driver what to do (release, drive low, presence) and
// reporting bus resets and unrecognized command bytes.
// The result register loads at the edge that accepts the item. Throughput is
// one item per cycle while the CRC unit is idle and the receiver keeps up; the
// result register frees its slot in the same cycle it is taken, so, CRC idle,
// in_ready follows out_ready while a result is pending, else stays high.
// A receiver stall holds the result and blocks the input only once the
// result register is full.
// Writing rom_id starts the CRC unit, which folds one id byte per cycle;
// in_ready is low while the CRC unit is busy so no ROM bit is read before the CRC
// byte is ready.
// Reset (rst_n low) restores default timing values, clears rom_id and the
// CRC, empties the result register and puts the engine in wait-for-reset
// mode. Registers sit on an APB-style port, 64-bit data, at byte address 8*i.
module one_wire_slave_bit_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] pulse_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  bus_action,
    output logic [11:0] start_delay_us,
    output logic [11:0] low_len_us,
    output logic [1:0]  event_kind,
    output logic [7:0]  event_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [2:0] MODE_WAIT_RESET = 3'd0;
    localparam logic [2:0] MODE_WAIT_CMD   = 3'd1;
    localparam logic [2:0] MODE_SRCH_SEND  = 3'd2;
    localparam logic [2:0] MODE_SRCH_COMP  = 3'd3;
    localparam logic [2:0] MODE_SRCH_CHECK = 3'd4;
    localparam logic [2:0] MODE_READ_ROM   = 3'd5;

    localparam int US_W  = owbe_pkg::US_W;
    localparam int TXW   = owbe_pkg::TXW;
    localparam int ROM_W = owbe_pkg::ID_BITS + 8;

    // Configuration registers
    logic [owbe_pkg::ID_BITS-1:0] rom_id_reg;
    logic [US_W-1:0] reset_min_reg;
    logic [US_W-1:0] bit_max_reg;
    logic [US_W-1:0] sample_reg;
    logic [US_W-1:0] presence_wait_reg;
    logic [US_W-1:0] presence_len_reg;
    logic [US_W-1:0] send_bit_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    // CRC unit
    logic [7:0] crc_reg;
    logic       crc_busy_reg;
    logic [2:0] crc_byte_reg;
    logic [7:0] crc_data;

    // Engine state
    logic [2:0]     mode_reg, mode_next;
    logic [7:0]     rx_byte_reg, rx_byte_next;
    logic [3:0]     rx_cnt_reg, rx_cnt_next;
    logic [TXW-1:0] tx_idx_reg, tx_idx_next;
    logic           last_bit_reg, last_bit_next;

    owbe_pkg::result_t res_next;
    owbe_pkg::result_t res_reg;
    logic              out_valid_reg;

    logic                     in_fire;
    logic                     pulse_bit;
    logic [ROM_W-1:0]         rom_full;
    logic                     rom_bit;
    logic [TXW:0]             tx_sum;
    logic                     tx_done;
    logic [7:0]               cmd_byte;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_comb
    begin
        unique case (cfg_idx)
            owbe_pkg::REG_ROM_ID:        prdata = 64'(rom_id_reg);
            owbe_pkg::REG_RESET_MIN:     prdata = 64'(reset_min_reg);
            owbe_pkg::REG_BIT_MAX:       prdata = 64'(bit_max_reg);
            owbe_pkg::REG_SAMPLE:        prdata = 64'(sample_reg);
            owbe_pkg::REG_PRESENCE_WAIT: prdata = 64'(presence_wait_reg);
            owbe_pkg::REG_PRESENCE_LEN:  prdata = 64'(presence_len_reg);
            owbe_pkg::REG_SEND_BIT:      prdata = 64'(send_bit_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_id_reg        <= '0;
            reset_min_reg     <= US_W'(400);
            bit_max_reg       <= US_W'(100);
            sample_reg        <= US_W'(25);
            presence_wait_reg <= US_W'(30);
            presence_len_reg  <= US_W'(150);
            send_bit_reg      <= US_W'(35);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                owbe_pkg::REG_ROM_ID:        rom_id_reg <= pwdata[owbe_pkg::ID_BITS-1:0];
                owbe_pkg::REG_RESET_MIN:     reset_min_reg <= pwdata[US_W-1:0];
                owbe_pkg::REG_BIT_MAX:       bit_max_reg <= pwdata[US_W-1:0];
                owbe_pkg::REG_SAMPLE:        sample_reg <= pwdata[US_W-1:0];
                owbe_pkg::REG_PRESENCE_WAIT: presence_wait_reg <= pwdata[US_W-1:0];
                owbe_pkg::REG_PRESENCE_LEN:  presence_len_reg <= pwdata[US_W-1:0];
                owbe_pkg::REG_SEND_BIT:      send_bit_reg <= pwdata[US_W-1:0];
                default:                     ;
            endcase
        end
    end

    // Fold one id byte into the CRC per cycle after each rom_id write
    assign crc_data = 8'(rom_id_reg >> {crc_byte_reg, 3'b000});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= '0;
            crc_busy_reg <= 1'b0;
            crc_byte_reg <= '0;
        end
        else if (cfg_wr && cfg_idx == owbe_pkg::REG_ROM_ID)
        begin
            crc_reg      <= '0;
            crc_busy_reg <= 1'b1;
            crc_byte_reg <= '0;
        end
        else if (crc_busy_reg)
        begin
            crc_reg      <= owbe_pkg::crc8_byte(crc_reg, crc_data);
            crc_byte_reg <= crc_byte_reg + 3'd1;
            if (crc_byte_reg == 3'(owbe_pkg::ID_BYTES - 1))
            begin
                crc_busy_reg <= 1'b0;
            end
        end
    end

    assign in_ready = !crc_busy_reg && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    assign rom_full  = {crc_reg, rom_id_reg};
    assign rom_bit   = rom_full[tx_idx_reg];
    assign tx_sum    = {1'b0, tx_idx_reg} + (TXW+1)'(1);
    assign tx_done   = tx_sum >= (TXW+1)'(owbe_pkg::ROM_BITS);
    assign pulse_bit = pulse_us < sample_reg;
    assign cmd_byte  = rx_byte_reg | (8'(pulse_bit) << rx_cnt_reg[2:0]);

    always_comb
    begin
        res_next      = '0;
        mode_next     = mode_reg;
        rx_byte_next  = rx_byte_reg;
        rx_cnt_next   = rx_cnt_reg;
        tx_idx_next   = tx_idx_reg;
        last_bit_next = last_bit_reg;

        priority if (pulse_us == '0)
        begin
            // ignored
        end
        else if (pulse_us > reset_min_reg)
        begin
            res_next.bus_action     = owbe_pkg::ACT_PRESENCE;
            res_next.start_delay_us = presence_wait_reg;
            res_next.low_len_us     = presence_len_reg;
            res_next.event_kind     = owbe_pkg::EV_RESET;
            rx_byte_next            = '0;
            rx_cnt_next             = '0;
            mode_next               = MODE_WAIT_CMD;
        end
        else if (pulse_us > bit_max_reg)
        begin
            // ignored as a bad slot
        end
        else
        begin
            unique case (mode_reg)
                MODE_WAIT_CMD:
                begin
                    if (rx_cnt_reg == 4'd7)
                    begin
                        rx_byte_next = '0;
                        rx_cnt_next  = '0;
                        unique case (cmd_byte)
                            owbe_pkg::CMD_SEARCH_ROM:
                            begin
                                mode_next     = MODE_SRCH_SEND;
                                tx_idx_next   = '0;
                                last_bit_next = 1'b0;
                            end
                            owbe_pkg::CMD_READ_ROM:
                            begin
                                mode_next     = MODE_READ_ROM;
                                tx_idx_next   = '0;
                                last_bit_next = 1'b0;
                            end
                            owbe_pkg::CMD_ALARM, owbe_pkg::CMD_MATCH_ROM,
                            owbe_pkg::CMD_SKIP_ROM, owbe_pkg::CMD_RESUME:
                            begin
                                // dropped silently
                            end
                            default:
                            begin
                                res_next.event_kind = owbe_pkg::EV_BYTE;
                                res_next.event_byte = cmd_byte;
                            end
                        endcase
                    end
                    else
                    begin
                        rx_byte_next = cmd_byte;
                        rx_cnt_next  = rx_cnt_reg + 4'd1;
                    end
                end
                MODE_READ_ROM:
                begin
                    if (pulse_bit)
                    begin
                        last_bit_next = rom_bit;
                        if (rom_bit)
                        begin
                            res_next.bus_action = owbe_pkg::ACT_RELEASE;
                        end
                        else
                        begin
                            res_next.bus_action = owbe_pkg::ACT_LOW;
                            res_next.low_len_us = send_bit_reg;
                        end
                        if (tx_done)
                        begin
                            tx_idx_next = '0;
                            mode_next   = MODE_WAIT_CMD;
                        end
                        else
                        begin
                            tx_idx_next = tx_sum[TXW-1:0];
                        end
                    end
                end
                MODE_SRCH_SEND:
                begin
                    if (pulse_bit)
                    begin
                        last_bit_next = rom_bit;
                        mode_next     = MODE_SRCH_COMP;
                        if (rom_bit)
                        begin
                            res_next.bus_action = owbe_pkg::ACT_RELEASE;
                        end
                        else
                        begin
                            res_next.bus_action = owbe_pkg::ACT_LOW;
                            res_next.low_len_us = send_bit_reg;
                        end
                    end
                end
                MODE_SRCH_COMP:
                begin
                    mode_next = MODE_SRCH_CHECK;
                    // send the complement of the last bit
                    if (!last_bit_reg)
                    begin
                        res_next.bus_action = owbe_pkg::ACT_RELEASE;
                    end
                    else
                    begin
                        res_next.bus_action = owbe_pkg::ACT_LOW;
                        res_next.low_len_us = send_bit_reg;
                    end
                end
                MODE_SRCH_CHECK:
                begin
                    if (pulse_bit != last_bit_reg)
                    begin
                        mode_next = MODE_WAIT_RESET;
                    end
                    else if (tx_done)
                    begin
                        tx_idx_next = '0;
                        mode_next   = MODE_WAIT_CMD;
                    end
                    else
                    begin
                        tx_idx_next = tx_sum[TXW-1:0];
                        mode_next   = MODE_SRCH_SEND;
                    end
                end
                default:
                begin
                    // wait for reset: drop bits
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_WAIT_RESET;
            rx_byte_reg   <= '0;
            rx_cnt_reg    <= '0;
            tx_idx_reg    <= '0;
            last_bit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg      <= mode_next;
                rx_byte_reg   <= rx_byte_next;
                rx_cnt_reg    <= rx_cnt_next;
                tx_idx_reg    <= tx_idx_next;
                last_bit_reg  <= last_bit_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign bus_action     = res_reg.bus_action;
    assign start_delay_us = res_reg.start_delay_us;
    assign low_len_us     = res_reg.low_len_us;
    assign event_kind     = res_reg.event_kind;
    assign event_byte     = res_reg.event_byte;

    a_no_item_during_crc: assert property (@(posedge clk) disable iff (!rst_n)
        crc_busy_reg |-> !in_ready)
        else $error("item accepted while CRC unit busy");

    a_rom_write_starts_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && cfg_idx == owbe_pkg::REG_ROM_ID) |=> crc_busy_reg && crc_byte_reg == 3'd0)
        else $error("rom_id write did not restart CRC unit");

    a_presence_with_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.bus_action == owbe_pkg::ACT_PRESENCE)
            |-> res_reg.event_kind == owbe_pkg::EV_RESET)
        else $error("presence pulse without reset event");

    a_byte_event_quiet_bus: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.event_kind == owbe_pkg::EV_BYTE)
            |-> res_reg.bus_action == owbe_pkg::ACT_NONE)
        else $error("byte event combined with bus action");

    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted item produced no result");

endmodule

FILE: tb/sv/one_wire_slave_bit_engine_unit_tb.sv
`timescale 1ns / 1ps

module one_wire_slave_bit_engine_unit_tb;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        ST_WAIT_RESET,
        ST_WAIT_CMD,
        ST_SRCH_SEND,
        ST_SRCH_COMP,
        ST_SRCH_CHECK,
        ST_READ_ROM
    } engine_mode_t;

    // Slave behavior model plus the queue of bus responses it owes
    class rom_responder_t;
        owbe_pkg::result_t          owed_q[$];
        logic [63:0]                rom_image;
        logic [owbe_pkg::US_W-1:0]  reset_min;
        logic [owbe_pkg::US_W-1:0]  bit_max;
        logic [owbe_pkg::US_W-1:0]  sample_th;
        logic [owbe_pkg::US_W-1:0]  pres_wait;
        logic [owbe_pkg::US_W-1:0]  pres_len;
        logic [owbe_pkg::US_W-1:0]  send_len;
        engine_mode_t               mode;
        logic [7:0]                 cmd_shift;
        logic [3:0]                 cmd_bits;
        logic [owbe_pkg::TXW-1:0]   rom_pos;
        logic                       sent_level;
        int                         errors;

        function new();
            rom_image  = with_crc(56'd0);
            reset_min  = 12'd400;
            bit_max    = 12'd100;
            sample_th  = 12'd25;
            pres_wait  = 12'd30;
            pres_len   = 12'd150;
            send_len   = 12'd35;
            mode       = ST_WAIT_RESET;
            cmd_shift  = 8'd0;
            cmd_bits   = 4'd0;
            rom_pos    = '0;
            sent_level = 1'b0;
            errors     = 0;
        endfunction

        // Append the reflected CRC-8 of the id, LSB of byte 0 first
        static function logic [63:0] with_crc(input logic [55:0] id);
            logic [7:0] crc;
            logic       mix;
            crc = 8'd0;
            for (int i = 0; i < owbe_pkg::ID_BITS; i++)
            begin
                mix = crc[0] ^ id[i];
                crc = crc >> 1;
                if (mix)
                begin
                    crc = crc ^ owbe_pkg::CRC_POLY;
                end
            end
            return {crc, id};
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [63:0] val);
            case (idx)
                owbe_pkg::REG_ROM_ID:        rom_image = with_crc(val[55:0]);
                owbe_pkg::REG_RESET_MIN:     reset_min = val[11:0];
                owbe_pkg::REG_BIT_MAX:       bit_max   = val[11:0];
                owbe_pkg::REG_SAMPLE:        sample_th = val[11:0];
                owbe_pkg::REG_PRESENCE_WAIT: pres_wait = val[11:0];
                owbe_pkg::REG_PRESENCE_LEN:  pres_len  = val[11:0];
                owbe_pkg::REG_SEND_BIT:      send_len  = val[11:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function owbe_pkg::result_t level_result(input logic level);
            owbe_pkg::result_t r;
            r = '0;
            if (level)
            begin
                r.bus_action = owbe_pkg::ACT_RELEASE;
            end
            else
            begin
                r.bus_action = owbe_pkg::ACT_LOW;
                r.low_len_us = send_len;
            end
            return r;
        endfunction

        function void step_rom();
            if (int'(rom_pos) + 1 >= owbe_pkg::ROM_BITS)
            begin
                rom_pos = '0;
                mode    = ST_WAIT_CMD;
            end
            else
            begin
                rom_pos = rom_pos + 1'b1;
            end
        endfunction

        function void note_pulse(input logic [11:0] p);
            owbe_pkg::result_t r;
            logic              b;
            r = '0;
            b = (p < sample_th);
            if (p != 12'd0 && p > reset_min)
            begin
                r.bus_action     = owbe_pkg::ACT_PRESENCE;
                r.start_delay_us = pres_wait;
                r.low_len_us     = pres_len;
                r.event_kind     = owbe_pkg::EV_RESET;
                cmd_shift        = 8'd0;
                cmd_bits         = 4'd0;
                mode             = ST_WAIT_CMD;
            end
            else if (p != 12'd0 && p <= bit_max)
            begin
                case (mode)
                    ST_WAIT_CMD:
                    begin
                        cmd_shift = cmd_shift | (8'(b) << cmd_bits[2:0]);
                        cmd_bits  = cmd_bits + 1'b1;
                        if (cmd_bits >= 4'd8)
                        begin
                            case (cmd_shift)
                                owbe_pkg::CMD_SEARCH_ROM:
                                begin
                                    mode       = ST_SRCH_SEND;
                                    rom_pos    = '0;
                                    sent_level = 1'b0;
                                end
                                owbe_pkg::CMD_READ_ROM:
                                begin
                                    mode       = ST_READ_ROM;
                                    rom_pos    = '0;
                                    sent_level = 1'b0;
                                end
                                owbe_pkg::CMD_ALARM, owbe_pkg::CMD_MATCH_ROM,
                                owbe_pkg::CMD_SKIP_ROM, owbe_pkg::CMD_RESUME: ;
                                default:
                                begin
                                    r.event_kind = owbe_pkg::EV_BYTE;
                                    r.event_byte = cmd_shift;
                                end
                            endcase
                            cmd_shift = 8'd0;
                            cmd_bits  = 4'd0;
                        end
                    end
                    ST_READ_ROM:
                    begin
                        if (b)
                        begin
                            sent_level = rom_image[rom_pos];
                            r          = level_result(sent_level);
                            step_rom();
                        end
                    end
                    ST_SRCH_SEND:
                    begin
                        if (b)
                        begin
                            sent_level = rom_image[rom_pos];
                            r          = level_result(sent_level);
                            mode       = ST_SRCH_COMP;
                        end
                    end
                    ST_SRCH_COMP:
                    begin
                        r    = level_result(~sent_level);
                        mode = ST_SRCH_CHECK;
                    end
                    ST_SRCH_CHECK:
                    begin
                        if (b != sent_level)
                        begin
                            mode = ST_WAIT_RESET;
                        end
                        else
                        begin
                            mode = ST_SRCH_SEND;
                            step_rom();
                        end
                    end
                    default: ;
                endcase
            end
            owed_q.push_back(r);
        endfunction

        function void field_err(input string name, input logic [11:0] want,
                                input logic [11:0] got);
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        endfunction

        function void check_result(input owbe_pkg::result_t got);
            owbe_pkg::result_t want;
            if (owed_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = owed_q.pop_front();
                if (got.bus_action !== want.bus_action)
                begin
                    field_err("bus_action", 12'(want.bus_action), 12'(got.bus_action));
                end
                if (got.start_delay_us !== want.start_delay_us)
                begin
                    field_err("start_delay_us", want.start_delay_us, got.start_delay_us);
                end
                if (got.low_len_us !== want.low_len_us)
                begin
                    field_err("low_len_us", want.low_len_us, got.low_len_us);
                end
                if (got.event_kind !== want.event_kind)
                begin
                    field_err("event_kind", 12'(want.event_kind), 12'(got.event_kind));
                end
                if (got.event_byte !== want.event_byte)
                begin
                    field_err("event_byte", 12'(want.event_byte), 12'(got.event_byte));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [11:0] pulse_us;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  bus_action;
    logic [11:0] start_delay_us;
    logic [11:0] low_len_us;
    logic [1:0]  event_kind;
    logic [7:0]  event_byte;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    rom_responder_t sb;
    logic           quiet;
    int             items_sent;
    int             calm_tx;
    int             calm_rx;
    int             stall_left;
    int             cycle_count;

    one_wire_slave_bit_engine_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pulse_us       (pulse_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bus_action     (bus_action),
        .start_delay_us (start_delay_us),
        .low_len_us     (low_len_us),
        .event_kind     (event_kind),
        .event_byte     (event_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Take results and stall the receiver in bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_result({bus_action, start_delay_us, low_len_us, event_kind,
                                 event_byte});
            end
            if (stall_left > 0 && !quiet)
            begin
                stall_left--;
                out_ready <= (stall_left == 0);
            end
            else if (quiet || calm_rx > 0)
            begin
                if (calm_rx > 0)
                begin
                    calm_rx--;
                end
                out_ready <= 1'b1;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                calm_rx = $urandom_range(20, 80);
                out_ready <= 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 17);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic send_pulse(input logic [11:0] p);
        int gap;
        gap = 0;
        if (!quiet)
        begin
            if (calm_tx > 0)
            begin
                calm_tx--;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                calm_tx = $urandom_range(10, 40);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 17);
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pulse_us <= p;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pulse(p);
        items_sent++;
    endtask

    // Pick a width that reads as the given bit under the current thresholds
    function automatic logic [11:0] pulse_for(input logic level);
        int lo;
        int hi;
        int cap;
        cap = (sb.bit_max < sb.reset_min) ? int'(sb.bit_max) : int'(sb.reset_min);
        if (level)
        begin
            lo = 1;
            hi = int'(sb.sample_th) - 1;
            if (cap < hi)
            begin
                hi = cap;
            end
        end
        else
        begin
            lo = (sb.sample_th < 12'd1) ? 1 : int'(sb.sample_th);
            hi = cap;
        end
        if (hi < lo)
        begin
            return 12'($urandom_range(0, 4095));
        end
        return 12'($urandom_range(lo, hi));
    endfunction

    function automatic logic [11:0] reset_pulse();
        if (sb.reset_min >= 12'd4095)
        begin
            return 12'd4095;
        end
        return 12'($urandom_range(int'(sb.reset_min) + 1, 4095));
    endfunction

    task automatic send_byte(input logic [7:0] cmd);
        for (int i = 0; i < 8; i++)
        begin
            send_pulse(pulse_for(cmd[i]));
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 5))
            0:       send_pulse(12'd0);
            1:       send_pulse(12'd4095);
            2:       send_pulse(pulse_for(1'($urandom_range(0, 1))));
            default: send_pulse(12'($urandom_range(0, 4095)));
        endcase
    endtask

    task automatic run_read_rom();
        int slots;
        slots = ($urandom_range(0, 3) == 0) ? owbe_pkg::ROM_BITS + $urandom_range(0, 3)
                                            : $urandom_range(1, 20);
        send_pulse(reset_pulse());
        send_byte(owbe_pkg::CMD_READ_ROM);
        for (int i = 0; i < slots; i++)
        begin
            // a write-zero slot here must not move the ROM pointer
            if ($urandom_range(0, 7) == 0)
            begin
                send_pulse(pulse_for(1'b0));
            end
            send_pulse(pulse_for(1'b1));
        end
    endtask

    task automatic run_search();
        int   steps;
        logic full;
        logic flip;
        full  = ($urandom_range(0, 5) == 0);
        steps = full ? owbe_pkg::ROM_BITS : $urandom_range(1, 24);
        send_pulse(reset_pulse());
        send_byte(owbe_pkg::CMD_SEARCH_ROM);
        for (int i = 0; i < steps; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_pulse(pulse_for(1'b0));
            end
            send_pulse(pulse_for(1'b1));
            send_pulse(pulse_for(1'($urandom_range(0, 1))));
            // diverge from the ROM on the last step of about half the partial searches
            flip = !full && (i == steps - 1) && ($urandom_range(0, 1) == 1);
            send_pulse(pulse_for(sb.rom_image[i] ^ flip));
        end
    endtask

    task automatic run_command();
        int         count;
        logic [7:0] cmd;
        count = $urandom_range(1, 3);
        send_pulse(reset_pulse());
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 7))
                0:       cmd = owbe_pkg::CMD_ALARM;
                1:       cmd = owbe_pkg::CMD_MATCH_ROM;
                2:       cmd = owbe_pkg::CMD_SKIP_ROM;
                3:       cmd = owbe_pkg::CMD_RESUME;
                default: cmd = 8'($urandom_range(0, 255));
            endcase
            send_byte(cmd);
        end
    endtask

    task automatic run_mix(input int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: run_search();
                3, 4, 5: run_read_rom();
                6, 7:    run_command();
                default: send_noise();
            endcase
        end
    endtask

    // Hold the sender until every owed response has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic load_timing(input int rmin, input int bmax, input int samp, input int pwait,
                               input int plen, input int sbit, input logic [55:0] id);
        drain();
        reg_write(owbe_pkg::REG_ROM_ID, {8'd0, id});
        reg_write(owbe_pkg::REG_RESET_MIN, 64'(rmin));
        reg_write(owbe_pkg::REG_BIT_MAX, 64'(bmax));
        reg_write(owbe_pkg::REG_SAMPLE, 64'(samp));
        reg_write(owbe_pkg::REG_PRESENCE_WAIT, 64'(pwait));
        reg_write(owbe_pkg::REG_PRESENCE_LEN, 64'(plen));
        reg_write(owbe_pkg::REG_SEND_BIT, 64'(sbit));
    endtask

    task automatic load_random_timing();
        int samp;
        int bmax;
        int rmin;
        samp = $urandom_range(2, 60);
        bmax = samp + $urandom_range(0, 80);
        rmin = bmax + $urandom_range(0, 400);
        load_timing(rmin, bmax, samp, $urandom_range(0, 4095), $urandom_range(1, 4095),
                    $urandom_range(1, 4095), 56'({$urandom(), $urandom()}));
    endtask

    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        pulse_us   = 12'd0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 6'd0;
        pwdata     = 64'd0;
        quiet      = 1'b0;
        items_sent = 0;
        calm_tx    = 0;
        calm_rx    = 0;
        stall_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass under the power-up timing values
        send_pulse(12'd0);
        send_pulse(12'd10);     // bit before any bus reset
        send_pulse(12'd4095);
        send_pulse(12'd250);    // too long for a bit, too short for a reset
        send_pulse(12'd401);
        send_pulse(12'd400);
        // unknown command 0x5A, slot widths on the sample and bit limits
        send_pulse(12'd100);
        send_pulse(12'd24);
        send_pulse(12'd25);
        send_pulse(12'd1);
        send_pulse(12'd24);
        send_pulse(12'd100);
        send_pulse(12'd1);
        send_pulse(12'd99);
        send_byte(owbe_pkg::CMD_SKIP_ROM);

        load_random_timing();
        run_mix(80);
        drain();
        run_mix(80);

        load_timing(1, 1, 1, 0, 1, 1, 56'd0);
        run_mix(20);
        load_timing(4095, 4095, 4095, 4095, 4095, 4095, {56{1'b1}});
        run_mix(20);

        load_random_timing();
        quiet = 1'b1;
        run_mix(90);

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/owbe_pkg.sv
sv/one_wire_slave_bit_engine_unit.sv
tb/sv/one_wire_slave_bit_engine_unit_tb.sv
